// ===== rtl/irt_pkg.sv =====
package irt_pkg;

   localparam int SlotsDefault  = 8;
   localparam int PiecesDefault = 16;
   localparam int HdrBytes      = 20;
   localparam int OffsetShift   = 3;

   typedef enum logic [2:0] {
      ST_UNFRAG  = 3'd0,
      ST_STORED  = 3'd1,
      ST_DONE    = 3'd2,
      ST_OVERLAP = 3'd3,
      ST_BEYOND  = 3'd4,
      ST_SECOND  = 3'd5,
      ST_FULL    = 3'd6,
      ST_TICK    = 3'd7
   } status_type;

   typedef struct packed {
      logic        tick;
      logic [31:0] src;
      logic [31:0] dst;
      logic [23:0] key;
      logic [16:0] off;
      logic [15:0] size;
      logic        mf;
   } job_type;

   typedef struct packed {
      status_type  status;
      logic [16:0] plen;
   } res_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SLOT,
      BK_OVL,
      BK_OVL_CHK,
      BK_SIZE,
      BK_WALK,
      BK_WALK_CHK,
      BK_CLEAR,
      BK_EMIT
   } back_state_type;

endpackage

// ===== rtl/ipv4_reassembly_tracker_top.sv =====
// channel  | valid     | stall     | payload
// request  | req_valid | req_stall | req_opcode .. req_more_fragments
// response | rsp_valid | rsp_stall | rsp_status, rsp_payload_length, rsp_total_length
// A two-entry queue takes items while the back end works on one at a time.
// A fragment is checked by an overlap scan over its slot's pieces and may then go on to
// the tiling walk, one piece RAM read each step; ticks skip both. Reset is synchronous
// and clears all valid bits at once. A stalled result holds the back end in its emit step.
module ipv4_reassembly_tracker_top #(
   parameter int SLOTS           = irt_pkg::SlotsDefault,
   parameter int PIECES_PER_SLOT = irt_pkg::PiecesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_source_ip,
   input  logic [31:0] req_dest_ip,
   input  logic [7:0]  req_protocol,
   input  logic [15:0] req_ident,
   input  logic [12:0] req_frag_offset,
   input  logic [15:0] req_payload_size,
   input  logic        req_more_fragments,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [16:0] rsp_payload_length,
   output logic [15:0] rsp_total_length
);
   import irt_pkg::*;

   logic q_valid, q_pop;
   job_type q_job;

   irt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_source_ip,
      .req_dest_ip, .req_protocol, .req_ident, .req_frag_offset,
      .req_payload_size, .req_more_fragments,
      .q_valid, .q_job, .q_pop
   );

   irt_back #(.SLOTS(SLOTS), .PIECES(PIECES_PER_SLOT)) u_back (
      .clock, .reset, .q_valid, .q_job, .q_pop,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_payload_length, .rsp_total_length
   );

`ifndef SYNTHESIS
   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_len_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_payload_length == 17'd0)
      else $error("length on non-complete result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped under stall");
`endif
endmodule

// ===== rtl/irt_ram.sv =====
module irt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/irt_front.sv =====
module irt_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_opcode,
   input  logic [31:0]     req_source_ip,
   input  logic [31:0]     req_dest_ip,
   input  logic [7:0]      req_protocol,
   input  logic [15:0]     req_ident,
   input  logic [12:0]     req_frag_offset,
   input  logic [15:0]     req_payload_size,
   input  logic            req_more_fragments,
   output logic            q_valid,
   output irt_pkg::job_type q_job,
   input  logic            q_pop
);
   import irt_pkg::*;

   job_type q_ff [2];
   job_type job_in;
   logic [1:0] cnt_ff;
   logic rd_ff, wr_ff;
   logic push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_job = q_ff[rd_ff];

   always_comb begin
      job_in.tick = req_opcode;
      job_in.src  = req_source_ip;
      job_in.dst  = req_dest_ip;
      job_in.key  = {req_protocol, req_ident};
      job_in.off  = {1'b0, req_frag_offset, 3'b000};
      job_in.size = req_payload_size;
      job_in.mf   = req_more_fragments;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= job_in;
      end
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (q_pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end
endmodule

// ===== rtl/irt_back.sv =====
module irt_back #(
   parameter int SLOTS  = irt_pkg::SlotsDefault,
   parameter int PIECES = irt_pkg::PiecesDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  irt_pkg::job_type q_job,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [16:0]      rsp_payload_length,
   output logic [15:0]      rsp_total_length
);
   import irt_pkg::*;

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW = $clog2(PIECES);
   localparam int AW = SW + PW;
   localparam int PS = 1 << PW;
   localparam int NP = SLOTS * PS;
   localparam int CW = PW + 1;

   back_state_type st_ff, st_in;
   job_type job_ff, job_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] free_ff, free_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [16:0] prog_ff, prog_in;
   res_type res_ff, res_in;
   res_type out_ff, out_in;
   logic out_v_ff, out_v_in;

   logic [SLOTS-1:0] sv_ff, sv_in, sf_ff, sf_in, last_ff, last_in;
   logic [31:0] ssrc_ff [SLOTS];
   logic [31:0] sdst_ff [SLOTS];
   logic [23:0] skey_ff [SLOTS];
   logic [16:0] ssize_ff [SLOTS];
   logic [NP-1:0] pv_ff, pv_in;

   logic slot_wr, size_wr;
   logic [16:0] size_wd;

   logic          pw_en;
   logic [AW-1:0] pw_addr, pr_addr;
   logic [31:0]   pw_data, pr_data;

   irt_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_pieces (
      .clock  (clock),
      .wr_en  (pw_en),
      .wr_addr(pw_addr),
      .wr_data(pw_data),
      .rd_addr(pr_addr),
      .rd_data(pr_data)
   );

   logic [SW-1:0] match_idx, free_idx;
   logic match_any, free_any;
   always_comb begin
      match_idx = '0;
      match_any = 1'b0;
      free_idx  = '0;
      free_any  = 1'b0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (sv_ff[s] && ssrc_ff[s] == job_ff.src && sdst_ff[s] == job_ff.dst
             && skey_ff[s] == job_ff.key) begin
            match_idx = SW'(s);
            match_any = 1'b1;
         end
         if (!sv_ff[s]) begin
            free_idx = SW'(s);
            free_any = 1'b1;
         end
      end
   end

   logic [PW-1:0] k_idx;
   logic [16:0] p_start, p_len, p_end, j_end;
   logic p_valid;
   assign k_idx   = k_ff[PW-1:0];
   assign p_valid = pv_ff[{slot_ff, k_idx}];
   assign p_start = {1'b0, pr_data[31:16]};
   assign p_len   = {1'b0, pr_data[15:0]};
   assign p_end   = p_start + p_len;
   assign j_end   = job_ff.off + {1'b0, job_ff.size};

   logic [AW-1:0] slot_base;
   assign slot_base = {slot_ff, {PW{1'b0}}};

   assign q_pop = (st_ff == BK_IDLE) && q_valid;
   assign rsp_valid = out_v_ff;
   assign rsp_status = out_ff.status;
   assign rsp_payload_length = out_ff.plen;
   always_comb begin
      logic [17:0] t;
      t = {1'b0, out_ff.plen} + 18'(HdrBytes);
      rsp_total_length = (out_ff.status != ST_DONE) ? 16'd0 :
                         (t > 18'd65535) ? 16'hffff : t[15:0];
   end

   always_comb begin
      st_in = st_ff;
      job_in = job_ff;
      slot_in = slot_ff;
      k_in = k_ff;
      free_in = free_ff;
      steps_in = steps_ff;
      prog_in = prog_ff;
      res_in = res_ff;
      out_in = out_ff;
      out_v_in = out_v_ff;
      sv_in = sv_ff;
      sf_in = sf_ff;
      last_in = last_ff;
      pv_in = pv_ff;
      slot_wr = 1'b0;
      size_wr = 1'b0;
      size_wd = '0;
      pw_en = 1'b0;
      pw_addr = slot_base + AW'(free_ff[PW-1:0]);
      pw_data = {job_ff.off[15:0], job_ff.size};
      pr_addr = slot_base + AW'(k_idx);

      if (out_v_ff && !rsp_stall) out_v_in = 1'b0;

      unique case (st_ff)
         BK_IDLE: begin
            if (q_valid) begin
               job_in = q_job;
               st_in = BK_SLOT;
            end
         end
         BK_SLOT: begin
            res_in.plen = '0;
            if (job_ff.tick) begin
               for (int s = 0; s < SLOTS; s++) begin
                  if (sv_ff[s] && !sf_ff[s]) begin
                     sv_in[s] = 1'b0;
                     for (int k = 0; k < PIECES; k++) pv_in[{SW'(s), PW'(k)}] = 1'b0;
                  end
               end
               sf_in = '0;
               res_in.status = ST_TICK;
               st_in = BK_EMIT;
            end else if (job_ff.off == '0 && !job_ff.mf) begin
               res_in.status = ST_UNFRAG;
               st_in = BK_EMIT;
            end else if (match_any) begin
               slot_in = match_idx;
               k_in = '0;
               free_in = CW'(PIECES);
               st_in = (job_ff.size != '0) ? BK_OVL : BK_SIZE;
            end else if (free_any) begin
               slot_in = free_idx;
               slot_wr = 1'b1;
               sv_in[free_idx] = 1'b1;
               sf_in[free_idx] = 1'b1;
               last_in[free_idx] = 1'b0;
               for (int k = 0; k < PIECES; k++)
                  pv_in[{free_idx, PW'(k)}] = 1'b0;
               k_in = '0;
               free_in = CW'(PIECES);
               st_in = (job_ff.size != '0) ? BK_OVL : BK_SIZE;
            end else begin
               res_in.status = ST_FULL;
               st_in = BK_EMIT;
            end
         end
         BK_OVL: st_in = BK_OVL_CHK;
         BK_OVL_CHK: begin
            if (p_valid) begin
               if (job_ff.off < p_end && p_start < j_end) begin
                  res_in.status = ST_OVERLAP;
                  st_in = BK_EMIT;
               end
            end else if (free_ff == CW'(PIECES)) begin
               free_in = k_ff;
            end
            if (st_in != BK_EMIT) begin
               if (k_ff == CW'(PIECES - 1)) begin
                  if (free_in == CW'(PIECES)) begin
                     res_in.status = ST_FULL;
                     st_in = BK_EMIT;
                  end else begin
                     free_ff_write: begin
                        pw_en = 1'b1;
                        pw_addr = slot_base + AW'(free_in[PW-1:0]);
                        pv_in[{slot_ff, free_in[PW-1:0]}] = 1'b1;
                     end
                     st_in = BK_SIZE;
                  end
               end else begin
                  k_in = k_ff + CW'(1);
                  st_in = BK_OVL;
               end
            end
         end
         BK_SIZE: begin
            if (j_end > ssize_ff[slot_ff] && last_ff[slot_ff]) begin
               res_in.status = ST_BEYOND;
               st_in = BK_EMIT;
            end else begin
               if (j_end > ssize_ff[slot_ff]) begin
                  size_wr = 1'b1;
                  size_wd = j_end;
               end
               if (!job_ff.mf && last_ff[slot_ff]) begin
                  res_in.status = ST_SECOND;
                  st_in = BK_EMIT;
               end else if (job_ff.mf && !last_ff[slot_ff]) begin
                  res_in.status = ST_STORED;
                  st_in = BK_EMIT;
               end else begin
                  last_in[slot_ff] = 1'b1;
                  prog_in = '0;
                  steps_in = '0;
                  k_in = '0;
                  st_in = BK_WALK;
               end
            end
         end
         BK_WALK: begin
            if (prog_ff >= ssize_ff[slot_ff]) begin
               st_in = BK_CLEAR;
            end else if (steps_ff > CW'(PIECES)) begin
               res_in.status = ST_STORED;
               st_in = BK_EMIT;
            end else begin
               st_in = BK_WALK_CHK;
            end
         end
         BK_WALK_CHK: begin
            if (p_valid && p_start == prog_ff) begin
               prog_in = prog_ff + p_len;
               steps_in = steps_ff + CW'(1);
               k_in = '0;
               st_in = BK_WALK;
            end else if (k_ff == CW'(PIECES - 1)) begin
               res_in.status = ST_STORED;
               st_in = BK_EMIT;
            end else begin
               k_in = k_ff + CW'(1);
               st_in = BK_WALK;
            end
         end
         BK_CLEAR: begin
            sv_in[slot_ff] = 1'b0;
            sf_in[slot_ff] = 1'b0;
            for (int k = 0; k < PIECES; k++) pv_in[{slot_ff, PW'(k)}] = 1'b0;
            res_in.status = ST_DONE;
            res_in.plen = ssize_ff[slot_ff];
            st_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (!out_v_ff || !rsp_stall) begin
               out_v_in = 1'b1;
               out_in.status = res_ff.status;
               out_in.plen = (res_ff.status == ST_DONE) ? res_ff.plen : '0;
               st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      slot_ff <= slot_in;
      k_ff <= k_in;
      free_ff <= free_in;
      steps_ff <= steps_in;
      prog_ff <= prog_in;
      res_ff <= res_in;
      out_ff <= out_in;
      last_ff <= last_in;
      if (slot_wr) begin
         ssrc_ff[slot_in] <= job_ff.src;
         sdst_ff[slot_in] <= job_ff.dst;
         skey_ff[slot_in] <= job_ff.key;
         ssize_ff[slot_in] <= '0;
      end
      if (size_wr) ssize_ff[slot_ff] <= size_wd;
      if (reset) begin
         st_ff <= BK_IDLE;
         out_v_ff <= 1'b0;
         sv_ff <= '0;
         sf_ff <= '0;
         pv_ff <= '0;
      end else begin
         st_ff <= st_in;
         out_v_ff <= out_v_in;
         sv_ff <= sv_in;
         sf_ff <= sf_in;
         pv_ff <= pv_in;
      end
   end
endmodule
